FILE: hw/rtl/ws2812_tx_pkg.sv
// shared constants and codes for the ws2812 pixel transmitter
package ws2812_tx_pkg;

    // color channels per frame (3 for rgb parts, 4 adds a trailing zero byte)
    localparam int COLOR_CHANNELS = 3;
    localparam int FRAME_BITS     = 8 * COLOR_CHANNELS;
    localparam int BIT_CNT_W      = $clog2(FRAME_BITS + 1);

    // stream payload widths
    localparam int CMD_W       = 2;
    localparam int COLOR_W     = 8;
    localparam int IN_DATA_W   = 3 * COLOR_W;
    localparam int OUT_DATA_W  = 8;
    localparam int TICK_W      = 8;
    localparam int LATCH_W     = 12;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_ENABLED     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS_PERCENT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH_TICKS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW_TICKS     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH_TICKS     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW_TICKS      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LATCH_LOW_TICKS    = 3'd6;

    // command codes carried on s_tuser
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd2;

    // result bit positions in m_tdata
    localparam int OUT_LEVEL_BIT    = 0;
    localparam int OUT_BUSY_BIT     = 1;
    localparam int OUT_ACCEPTED_BIT = 2;

    // brightness scaling: floor(c*b/100) == (c * b * SCALE_RECIP) >> SCALE_SHIFT
    // for every 8-bit c and b up to 100
    localparam int BRIGHT_W     = 7;
    localparam int BRIGHT_MAX   = 100;
    localparam int SCALE_SHIFT  = 19;
    localparam int SCALE_RECIP  = (2 ** SCALE_SHIFT + BRIGHT_MAX - 1) / BRIGHT_MAX;
    localparam int FACTOR_W     = BRIGHT_W + 13;
    localparam int PROD_W       = COLOR_W + FACTOR_W;

    // reset values of the registers
    localparam logic                 RST_OUTPUT_ENABLED = 1'b1;
    localparam logic [BRIGHT_W-1:0]  RST_BRIGHTNESS     = 7'd50;
    localparam logic [TICK_W-1:0]    RST_ZERO_HIGH      = 8'd4;
    localparam logic [TICK_W-1:0]    RST_ZERO_LOW       = 8'd8;
    localparam logic [TICK_W-1:0]    RST_ONE_HIGH       = 8'd8;
    localparam logic [TICK_W-1:0]    RST_ONE_LOW        = 8'd4;
    localparam logic [LATCH_W-1:0]   RST_LATCH_LOW      = 12'd500;
    localparam logic [FACTOR_W-1:0]  RST_FACTOR         =
        FACTOR_W'(int'(RST_BRIGHTNESS) * SCALE_RECIP);

endpackage

FILE: hw/rtl/ws2812_pixel_transmitter.sv
// ws2812 pixel transmitter: command decode, frame shifter and bit timing
//
// One item is taken per clock, a tick, a color load or a refresh, and its
// single result appears on the m_ side from an output register; the input
// stalls only while that register holds a result that is not being taken. A
// tick moves the line waveform one step. A load or refresh starts a frame only
// while the line is idle (a refresh only once a color was loaded), scaling each
// channel by the brightness with one 8x20 multiplier per channel in that same
// cycle; the scale factor itself is formed when brightness or enable is written.
// Bits go out red first, msb first, followed by the latch low period. A zero
// tick count lasts one tick. No clearing pass is needed after reset.
module ws2812_pixel_transmitter (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [ws2812_tx_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ws2812_tx_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [ws2812_tx_pkg::IN_DATA_W-1:0]     s_tdata,   // red, green, blue
    input  logic [ws2812_tx_pkg::CMD_W-1:0]         s_tuser,   // cmd
    // result items
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [ws2812_tx_pkg::OUT_DATA_W-1:0]    m_tdata    // line_level, busy_res,
                                                               // accepted, zero pad
);
    import ws2812_tx_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_LATCH = 2'd3;

    function automatic logic [LATCH_W-1:0] at_least_one(input logic [LATCH_W-1:0] v);
        return (v == '0) ? LATCH_W'(1) : v;
    endfunction

    function automatic logic [COLOR_W-1:0] scale_channel(input logic [COLOR_W-1:0] c,
                                                         input logic [FACTOR_W-1:0] f);
        logic [PROD_W-1:0] p;
        p = PROD_W'(c) * PROD_W'(f);
        return p[SCALE_SHIFT +: COLOR_W];
    endfunction

    // configuration registers
    logic                 enable_reg,     enable_next;
    logic [BRIGHT_W-1:0]  bright_reg,     bright_next;
    logic [FACTOR_W-1:0]  factor_reg,     factor_next;
    logic [TICK_W-1:0]    zero_high_reg,  zero_high_next;
    logic [TICK_W-1:0]    zero_low_reg,   zero_low_next;
    logic [TICK_W-1:0]    one_high_reg,   one_high_next;
    logic [TICK_W-1:0]    one_low_reg,    one_low_next;
    logic [LATCH_W-1:0]   latch_low_reg,  latch_low_next;

    // transmitter state
    logic [COLOR_W-1:0]    red_reg,   red_next;
    logic [COLOR_W-1:0]    green_reg, green_next;
    logic [COLOR_W-1:0]    blue_reg,  blue_next;
    logic                  color_valid_reg, color_valid_next;
    logic [FRAME_BITS-1:0] frame_shift_reg, frame_shift_next;
    logic [BIT_CNT_W-1:0]  bits_left_reg,   bits_left_next;
    logic [1:0]            phase_reg,       phase_next;
    logic [LATCH_W-1:0]    ticks_left_reg,  ticks_left_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg,  out_data_next;

    logic                  s_accept;
    logic [CMD_W-1:0]      cmd;
    logic [COLOR_W-1:0]    src_red, src_green, src_blue;
    logic [3*COLOR_W-1:0]  scaled_rgb;
    logic [FRAME_BITS-1:0] new_frame;
    logic [FRAME_BITS-1:0] shifted_frame;
    logic [BIT_CNT_W-1:0]  bits_dec;
    logic                  start_frame;
    logic                  level;
    logic                  busy;
    logic                  accepted;
    logic                  en_w;
    logic [BRIGHT_W-1:0]   br_w;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cmd       = s_tuser;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // configuration writes
    always_comb begin
        enable_next    = enable_reg;
        bright_next    = bright_reg;
        zero_high_next = zero_high_reg;
        zero_low_next  = zero_low_reg;
        one_high_next  = one_high_reg;
        one_low_next   = one_low_reg;
        latch_low_next = latch_low_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_OUTPUT_ENABLED:     enable_next = cfg_data[0];
                REG_BRIGHTNESS_PERCENT: begin
                    bright_next = (cfg_data[BRIGHT_W-1:0] > BRIGHT_W'(BRIGHT_MAX))
                                ? BRIGHT_W'(BRIGHT_MAX) : cfg_data[BRIGHT_W-1:0];
                end
                REG_ZERO_HIGH_TICKS:    zero_high_next = cfg_data[TICK_W-1:0];
                REG_ZERO_LOW_TICKS:     zero_low_next  = cfg_data[TICK_W-1:0];
                REG_ONE_HIGH_TICKS:     one_high_next  = cfg_data[TICK_W-1:0];
                REG_ONE_LOW_TICKS:      one_low_next   = cfg_data[TICK_W-1:0];
                REG_LATCH_LOW_TICKS:    latch_low_next = cfg_data[LATCH_W-1:0];
                default: ;
            endcase
        end
        en_w        = enable_next;
        br_w        = bright_next;
        // scale factor ready in the same edge as the write
        factor_next = en_w ? FACTOR_W'(int'(br_w) * SCALE_RECIP) : '0;
    end

    // frame built from the color that the frame starts with
    assign src_red    = (cmd == CMD_LOAD) ? s_tdata[COLOR_W-1:0]           : red_reg;
    assign src_green  = (cmd == CMD_LOAD) ? s_tdata[2*COLOR_W-1:COLOR_W]   : green_reg;
    assign src_blue   = (cmd == CMD_LOAD) ? s_tdata[3*COLOR_W-1:2*COLOR_W] : blue_reg;
    assign scaled_rgb = {scale_channel(src_red,   factor_reg),
                         scale_channel(src_green, factor_reg),
                         scale_channel(src_blue,  factor_reg)};
    assign new_frame  = FRAME_BITS'(scaled_rgb) << (FRAME_BITS - 3 * COLOR_W);

    assign shifted_frame = frame_shift_reg << 1;
    assign bits_dec      = (bits_left_reg != '0) ? bits_left_reg - BIT_CNT_W'(1)
                                                 : bits_left_reg;

    always_comb begin
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        color_valid_next = color_valid_reg;
        frame_shift_next = frame_shift_reg;
        bits_left_next   = bits_left_reg;
        phase_next       = phase_reg;
        ticks_left_next  = ticks_left_reg;
        start_frame      = 1'b0;
        level            = 1'b0;
        accepted         = 1'b0;

        if (s_accept) begin
            case (cmd)
                CMD_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        level = (phase_reg == PH_HIGH);
                        if (ticks_left_reg > LATCH_W'(1)) begin
                            ticks_left_next = ticks_left_reg - LATCH_W'(1);
                        end else begin
                            unique case (phase_reg)
                                PH_HIGH: begin
                                    phase_next      = PH_LOW;
                                    ticks_left_next = at_least_one(LATCH_W'(
                                        frame_shift_reg[FRAME_BITS-1] ? one_low_reg
                                                                      : zero_low_reg));
                                end
                                PH_LOW: begin
                                    frame_shift_next = shifted_frame;
                                    bits_left_next   = bits_dec;
                                    if (bits_dec != '0) begin
                                        phase_next      = PH_HIGH;
                                        ticks_left_next = at_least_one(LATCH_W'(
                                            shifted_frame[FRAME_BITS-1] ? one_high_reg
                                                                        : zero_high_reg));
                                    end else begin
                                        phase_next      = PH_LATCH;
                                        ticks_left_next = at_least_one(latch_low_reg);
                                    end
                                end
                                PH_LATCH: begin
                                    phase_next       = PH_IDLE;
                                    ticks_left_next  = '0;
                                    frame_shift_next = '0;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                CMD_LOAD: begin
                    if (phase_reg == PH_IDLE) begin
                        red_next         = src_red;
                        green_next       = src_green;
                        blue_next        = src_blue;
                        color_valid_next = 1'b1;
                        start_frame      = 1'b1;
                    end
                end
                CMD_REFRESH: begin
                    if (phase_reg == PH_IDLE && color_valid_reg) begin
                        start_frame = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (start_frame) begin
            accepted         = 1'b1;
            frame_shift_next = new_frame;
            bits_left_next   = BIT_CNT_W'(FRAME_BITS);
            phase_next       = PH_HIGH;
            ticks_left_next  = at_least_one(LATCH_W'(
                new_frame[FRAME_BITS-1] ? one_high_reg : zero_high_reg));
        end

        // a tick reports the tick it spent, other items the state they leave
        busy = (cmd == CMD_TICK) ? (phase_reg != PH_IDLE) : (phase_next != PH_IDLE);
    end

    // output register, refilled on every accepted item
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (s_accept) begin
            out_valid_next                  = 1'b1;
            out_data_next                   = '0;
            out_data_next[OUT_LEVEL_BIT]    = level;
            out_data_next[OUT_BUSY_BIT]     = busy;
            out_data_next[OUT_ACCEPTED_BIT] = accepted;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= RST_OUTPUT_ENABLED;
            bright_reg      <= RST_BRIGHTNESS;
            factor_reg      <= RST_FACTOR;
            zero_high_reg   <= RST_ZERO_HIGH;
            zero_low_reg    <= RST_ZERO_LOW;
            one_high_reg    <= RST_ONE_HIGH;
            one_low_reg     <= RST_ONE_LOW;
            latch_low_reg   <= RST_LATCH_LOW;
            color_valid_reg <= 1'b0;
            bits_left_reg   <= '0;
            phase_reg       <= PH_IDLE;
            ticks_left_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            enable_reg      <= enable_next;
            bright_reg      <= bright_next;
            factor_reg      <= factor_next;
            zero_high_reg   <= zero_high_next;
            zero_low_reg    <= zero_low_next;
            one_high_reg    <= one_high_next;
            one_low_reg     <= one_low_next;
            latch_low_reg   <= latch_low_next;
            color_valid_reg <= color_valid_next;
            bits_left_reg   <= bits_left_next;
            phase_reg       <= phase_next;
            ticks_left_reg  <= ticks_left_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        red_reg         <= red_next;
        green_reg       <= green_next;
        blue_reg        <= blue_next;
        frame_shift_reg <= frame_shift_next;
        out_data_reg    <= out_data_next;
    end

endmodule

FILE: hw/rtl/ws2812_tx_checker.sv
// port-level checks for the ws2812 pixel transmitter, bound to the top level
module ws2812_tx_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [ws2812_tx_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ws2812_tx_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                    s_tvalid,
    input  logic                                    s_tready,
    input  logic [ws2812_tx_pkg::IN_DATA_W-1:0]     s_tdata,   // red, green, blue
    input  logic [ws2812_tx_pkg::CMD_W-1:0]         s_tuser,   // cmd
    input  logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic [ws2812_tx_pkg::OUT_DATA_W-1:0]    m_tdata    // line_level, busy_res,
                                                               // accepted, zero pad
);
    import ws2812_tx_pkg::*;

    logic cfg_seen;
    logic s_accept;

    assign cfg_seen = cfg_valid && cfg_ready && (cfg_index != '1) && (cfg_data != '1);
    assign s_accept = s_tvalid && s_tready;

    // a started frame always leaves the line busy
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_ACCEPTED_BIT] |-> m_tdata[OUT_BUSY_BIT])
        else $error("frame started but busy not reported");

    // the line is only driven high while a frame is in progress
    a_level_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_LEVEL_BIT] |-> m_tdata[OUT_BUSY_BIT])
        else $error("line high outside a frame");

    // items that cannot start a frame never report one in their result
    a_no_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser != CMD_LOAD && s_tuser != CMD_REFRESH
        |=> m_tvalid && !m_tdata[OUT_ACCEPTED_BIT])
        else $error("tick or unused command reported a frame start");

    // load and refresh items never drive the line
    a_cmd_level: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser != CMD_TICK |=> m_tvalid && !m_tdata[OUT_LEVEL_BIT])
        else $error("non-tick item drove the line");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn || cfg_seen)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind ws2812_pixel_transmitter ws2812_tx_checker u_ws2812_tx_checker (.*);

FILE: verif/ws2812_pixel_transmitter_tb.sv
`timescale 1ns / 100ps
// self-checking stream testbench for the ws2812 pixel transmitter
module ws2812_pixel_transmitter_tb;
    import ws2812_tx_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_MAX  = 10;
    localparam int PHASES      = 12;

    localparam logic [CMD_W-1:0]       CMD_UNUSED   = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

    localparam int RX_FREE     = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    typedef enum logic [1:0] {LINE_IDLE, LINE_HIGH, LINE_LOW, LINE_LATCH} line_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_item_t;

    typedef struct packed {
        logic level;
        logic busy;
        logic accepted;
    } line_result_t;

    typedef struct {
        pixel_item_t  item;
        bit           typed;
        line_result_t res;
    } opening_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [CMD_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;

    ws2812_pixel_transmitter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // line model: registers
    logic                  cfg_enable;
    logic [BRIGHT_W-1:0]   cfg_bright;
    logic [TICK_W-1:0]     cfg_zero_hi;
    logic [TICK_W-1:0]     cfg_zero_lo;
    logic [TICK_W-1:0]     cfg_one_hi;
    logic [TICK_W-1:0]     cfg_one_lo;
    logic [LATCH_W-1:0]    cfg_latch;

    // line model: pixel and waveform state
    logic [COLOR_W-1:0]    held_red;
    logic [COLOR_W-1:0]    held_green;
    logic [COLOR_W-1:0]    held_blue;
    logic                  held_ok;
    logic [FRAME_BITS-1:0] shreg;
    logic [BIT_CNT_W-1:0]  bits_left;
    line_state_t           line_state;
    logic [LATCH_W-1:0]    ticks_left;

    line_result_t waveform_q[$];
    opening_row_t opening_rows[$];
    int           bad_results;
    int           cycle_count;
    int           burst_left;
    bit           gaps_on;

    function automatic logic [LATCH_W-1:0] min_one(input logic [LATCH_W-1:0] v);
        return (v == '0) ? LATCH_W'(1) : v;
    endfunction

    function automatic logic [COLOR_W-1:0] dim(input logic [COLOR_W-1:0] c);
        int pct;
        pct = cfg_enable ? int'(cfg_bright) : 0;
        return COLOR_W'((int'(c) * pct) / BRIGHT_MAX);
    endfunction

    task automatic begin_bit();
        line_state = LINE_HIGH;
        ticks_left = min_one(shreg[FRAME_BITS-1] ? cfg_one_hi : cfg_zero_hi);
    endtask

    task automatic start_frame();
        shreg = '0;
        shreg[FRAME_BITS-1 -: 3*COLOR_W] = {dim(held_red), dim(held_green), dim(held_blue)};
        bits_left = BIT_CNT_W'(FRAME_BITS);
        begin_bit();
    endtask

    task automatic advance_tick();
        if (ticks_left > 1) begin
            ticks_left = ticks_left - 1'b1;
        end else if (line_state == LINE_HIGH) begin
            line_state = LINE_LOW;
            ticks_left = min_one(shreg[FRAME_BITS-1] ? cfg_one_lo : cfg_zero_lo);
        end else if (line_state == LINE_LOW) begin
            shreg = shreg << 1;
            if (bits_left > 0) bits_left = bits_left - 1'b1;
            if (bits_left > 0) begin
                begin_bit();
            end else begin
                line_state = LINE_LATCH;
                ticks_left = min_one(cfg_latch);
            end
        end else begin
            line_state = LINE_IDLE;
            ticks_left = '0;
            shreg      = '0;
        end
    endtask

    task automatic waveform_step(input pixel_item_t it, output line_result_t r);
        r = '0;
        if (it.cmd == CMD_TICK) begin
            r.busy = (line_state != LINE_IDLE);
            if (r.busy) begin
                r.level = (line_state == LINE_HIGH);
                advance_tick();
            end
        end else begin
            if (it.cmd == CMD_LOAD && line_state == LINE_IDLE) begin
                held_red   = it.red;
                held_green = it.green;
                held_blue  = it.blue;
                held_ok    = 1'b1;
                start_frame();
                r.accepted = 1'b1;
            end else if (it.cmd == CMD_REFRESH && line_state == LINE_IDLE && held_ok) begin
                start_frame();
                r.accepted = 1'b1;
            end
            r.busy = (line_state != LINE_IDLE);
        end
    endtask

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_OUTPUT_ENABLED:     cfg_enable  = val[0];
            REG_BRIGHTNESS_PERCENT: cfg_bright  = (val[BRIGHT_W-1:0] > BRIGHT_MAX) ?
                                                  BRIGHT_W'(BRIGHT_MAX) : val[BRIGHT_W-1:0];
            REG_ZERO_HIGH_TICKS:    cfg_zero_hi = val[TICK_W-1:0];
            REG_ZERO_LOW_TICKS:     cfg_zero_lo = val[TICK_W-1:0];
            REG_ONE_HIGH_TICKS:     cfg_one_hi  = val[TICK_W-1:0];
            REG_ONE_LOW_TICKS:      cfg_one_lo  = val[TICK_W-1:0];
            REG_LATCH_LOW_TICKS:    cfg_latch   = val[LATCH_W-1:0];
            default: ;
        endcase
    endtask

    // random bits above the register width, which the block must drop
    function automatic logic [CFG_DATA_W-1:0] with_junk(input int val, input int width);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        for (int i = 0; i < width; i++) d[i] = val[i];
        return d;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    task automatic set_timing(input int en, input int bright, input int zh, input int zl,
                              input int oh, input int ol, input int latch);
        write_reg(REG_OUTPUT_ENABLED,     with_junk(en, 1));
        write_reg(REG_BRIGHTNESS_PERCENT, with_junk(bright, BRIGHT_W));
        write_reg(REG_ZERO_HIGH_TICKS,    with_junk(zh, TICK_W));
        write_reg(REG_ZERO_LOW_TICKS,     with_junk(zl, TICK_W));
        write_reg(REG_ONE_HIGH_TICKS,     with_junk(oh, TICK_W));
        write_reg(REG_ONE_LOW_TICKS,      with_junk(ol, TICK_W));
        write_reg(REG_LATCH_LOW_TICKS,    with_junk(latch, LATCH_W));
    endtask

    task automatic send_item(input pixel_item_t it, input bit typed, input line_result_t want);
        line_result_t r;
        @(negedge aclk);
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.blue, it.green, it.red};
        s_tuser  <= it.cmd;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) burst_left--;
        waveform_step(it, r);
        waveform_q.push_back(typed ? want : r);
    endtask

    // drop valid and wait until every result is back and the block is quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (waveform_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    function automatic logic [COLOR_W-1:0] pick_color();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) return '0;
        if (roll < 30) return '1;
        return COLOR_W'($urandom);
    endfunction

    // mostly complete frames: loads while idle, ticks while busy, some noise
    function automatic pixel_item_t pick_item();
        pixel_item_t it;
        int roll;
        roll     = $urandom_range(99);
        it.red   = pick_color();
        it.green = pick_color();
        it.blue  = pick_color();
        if (line_state == LINE_IDLE) begin
            if (roll < 62)      it.cmd = CMD_LOAD;
            else if (roll < 80) it.cmd = CMD_REFRESH;
            else if (roll < 92) it.cmd = CMD_TICK;
            else                it.cmd = CMD_UNUSED;
        end else begin
            if (roll < 92)      it.cmd = CMD_TICK;
            else if (roll < 95) it.cmd = CMD_LOAD;
            else if (roll < 97) it.cmd = CMD_REFRESH;
            else                it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic run_stream(input int n_items, input bit drain);
        pixel_item_t it;
        line_result_t none;
        none = '0;
        for (int i = 0; i < n_items; i++) begin
            it = pick_item();
            send_item(it, 1'b0, none);
        end
        while (drain && line_state != LINE_IDLE) begin
            it     = pick_item();
            it.cmd = CMD_TICK;
            send_item(it, 1'b0, none);
        end
    endtask

    function automatic void add_row(input logic [CMD_W-1:0] cmd, input int r, input int g,
                                    input int b, input bit typed, input bit lvl,
                                    input bit busy, input bit acc);
        opening_row_t row;
        row.item.cmd      = cmd;
        row.item.red      = COLOR_W'(r);
        row.item.green    = COLOR_W'(g);
        row.item.blue     = COLOR_W'(b);
        row.typed         = typed;
        row.res.level     = lvl;
        row.res.busy      = busy;
        row.res.accepted  = acc;
        opening_rows.push_back(row);
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: switches between always ready, random stalls and a fixed pattern
    initial begin
        int mode;
        int span;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(RX_PERIODIC);
            span = $urandom_range(20, 200);
            for (int k = 0; k < span; k++) begin
                @(negedge aclk);
                case (mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(99) < 60);
                    default:   m_tready <= ((k % 8) < 5);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        line_result_t want;
        logic [OUT_DATA_W-1:0] pad;
        if (aresetn && m_tvalid && m_tready) begin
            pad = m_tdata;
            pad[OUT_LEVEL_BIT]    = 1'b0;
            pad[OUT_BUSY_BIT]     = 1'b0;
            pad[OUT_ACCEPTED_BIT] = 1'b0;
            if (waveform_q.size() == 0) begin
                bad_results++;
                if (bad_results <= REPORT_MAX)
                    $display("cycle %0d: result %0h with none outstanding", cycle_count, m_tdata);
            end else begin
                want = waveform_q.pop_front();
                if (m_tdata[OUT_LEVEL_BIT] !== want.level || m_tdata[OUT_BUSY_BIT] !== want.busy ||
                    m_tdata[OUT_ACCEPTED_BIT] !== want.accepted || pad !== '0) begin
                    bad_results++;
                    if (bad_results <= REPORT_MAX)
                        $display("cycle %0d: level %0b/%0b busy %0b/%0b accepted %0b/%0b pad %0h",
                                 cycle_count, want.level, m_tdata[OUT_LEVEL_BIT], want.busy,
                                 m_tdata[OUT_BUSY_BIT], want.accepted,
                                 m_tdata[OUT_ACCEPTED_BIT], pad);
                end
            end
        end
    end

    initial begin
        bad_results = 0;
        cycle_count = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_TICK;

        cfg_enable  = RST_OUTPUT_ENABLED;
        cfg_bright  = RST_BRIGHTNESS;
        cfg_zero_hi = RST_ZERO_HIGH;
        cfg_zero_lo = RST_ZERO_LOW;
        cfg_one_hi  = RST_ONE_HIGH;
        cfg_one_lo  = RST_ONE_LOW;
        cfg_latch   = RST_LATCH_LOW;
        held_red    = '0;
        held_green  = '0;
        held_blue   = '0;
        held_ok     = 1'b0;
        shreg       = '0;
        bits_left   = '0;
        line_state  = LINE_IDLE;
        ticks_left  = '0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // opening rows at reset settings
        add_row(CMD_TICK,    8'h00, 8'h00, 8'h00, 1, 0, 0, 0);  // tick while idle
        add_row(CMD_REFRESH, 8'hff, 8'hff, 8'hff, 1, 0, 0, 0);  // refresh with no color yet
        add_row(CMD_UNUSED,  8'hff, 8'hff, 8'hff, 1, 0, 0, 0);
        add_row(CMD_LOAD,    8'hff, 8'h00, 8'h80, 1, 0, 1, 1);
        add_row(CMD_LOAD,    8'h12, 8'h34, 8'h56, 1, 0, 1, 0);  // refused, frame running
        add_row(CMD_REFRESH, 8'h00, 8'h00, 8'h00, 1, 0, 1, 0);
        add_row(CMD_UNUSED,  8'h00, 8'h00, 8'h00, 1, 0, 1, 0);
        add_row(CMD_TICK,    8'h00, 8'h00, 8'h00, 1, 1, 1, 0);  // first bit starts high
        for (int i = 0; i < 14; i++)
            add_row(CMD_TICK, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                    0, 0, 0, 0);
        foreach (opening_rows[i])
            send_item(opening_rows[i].item, opening_rows[i].typed, opening_rows[i].res);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            gaps_on = !(p == 5 || p == 9);
            case (p)
                0: set_timing(1, 127, 255, 255, 255, 255, 4095);
                1: set_timing(0, 0, 0, 0, 0, 0, 0);
                2: set_timing(1, 100, 1, 1, 1, 1, 40);
                default: set_timing($urandom_range(99) < 85, $urandom_range(127),
                                    $urandom_range(3), $urandom_range(3), $urandom_range(3),
                                    $urandom_range(3), $urandom_range(10));
            endcase
            if (p == 3) write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
            @(negedge aclk);
            cfg_valid <= 1'b0;
            case (p)
                // long counts: the frame is left running into the next settings
                0: run_stream(150, 1'b0);
                1: run_stream(60, 1'b1);
                2: run_stream(30, 1'b1);
                default: run_stream(30, p == PHASES - 1);
            endcase
        end

        settle();
        repeat (10) @(posedge aclk);
        if (bad_results == 0 && waveform_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
